// ----- rtl/tpc_pkg.sv -----
package tpc_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int QUEUE_DEPTH   = 2;
	localparam int NVERT         = 3;
	localparam int NCOORD        = 4;

	// configuration register indexes
	localparam logic [1:0] REG_PLANE_A = 2'd0;
	localparam logic [1:0] REG_PLANE_B = 2'd1;
	localparam logic [1:0] REG_PLANE_C = 2'd2;
	localparam logic [1:0] REG_PLANE_D = 2'd3;

	// one vertex: x, y, z, w
	typedef logic [NCOORD-1:0][31:0] vtx_t;
	// one triangle: three vertices
	typedef logic [NVERT-1:0][NCOORD-1:0][31:0] tri_t;

	// signed distance width for a given fraction width
	function automatic int dist_width(input int frac_bits);
		return 66 - frac_bits;
	endfunction

endpackage

// ----- rtl/tpc_if.sv -----
interface tpc_tri_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] a_x;
	logic signed [31:0] a_y;
	logic signed [31:0] a_z;
	logic signed [31:0] a_w;
	logic signed [31:0] b_x;
	logic signed [31:0] b_y;
	logic signed [31:0] b_z;
	logic signed [31:0] b_w;
	logic signed [31:0] c_x;
	logic signed [31:0] c_y;
	logic signed [31:0] c_z;
	logic signed [31:0] c_w;

	modport source (output valid, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w,
		c_x, c_y, c_z, c_w, input ready);
	modport sink (input valid, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w,
		c_x, c_y, c_z, c_w, output ready);
endinterface

interface tpc_vtx_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] out_x;
	logic signed [31:0] out_y;
	logic signed [31:0] out_z;
	logic signed [31:0] out_w;
	logic               end_of_triangle;
	logic               last;

	modport source (output valid, out_x, out_y, out_z, out_w, end_of_triangle, last,
		input ready);
	modport sink (input valid, out_x, out_y, out_z, out_w, end_of_triangle, last,
		output ready);
endinterface

// ----- rtl/tpc_front.sv -----
module tpc_front #(
	parameter int FRAC_BITS = tpc_pkg::FRAC_BITS_DEF,
	parameter int DW        = tpc_pkg::dist_width(FRAC_BITS)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	tpc_tri_if.sink              tri_in,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [31:0]          cfg_data,
	output logic                 push_valid,
	input  logic                 push_ready,
	output tpc_pkg::tri_t        push_tri,
	output logic [2:0][DW-1:0]   push_dist
);

	logic signed [31:0] plane_q [4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_q[0] <= '0;
			plane_q[1] <= '0;
			plane_q[2] <= 32'(1) << FRAC_BITS;
			plane_q[3] <= -(32'(1) << FRAC_BITS);
		end else if (cfg_we) begin
			unique case (cfg_index)
				tpc_pkg::REG_PLANE_A: plane_q[0] <= cfg_data;
				tpc_pkg::REG_PLANE_B: plane_q[1] <= cfg_data;
				tpc_pkg::REG_PLANE_C: plane_q[2] <= cfg_data;
				tpc_pkg::REG_PLANE_D: plane_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	tpc_pkg::tri_t vin;
	assign vin[0] = {tri_in.a_w, tri_in.a_z, tri_in.a_y, tri_in.a_x};
	assign vin[1] = {tri_in.b_w, tri_in.b_z, tri_in.b_y, tri_in.b_x};
	assign vin[2] = {tri_in.c_w, tri_in.c_z, tri_in.c_y, tri_in.c_x};

	// stall-able two stage pipe: products, then pair sums
	logic valid_s1, valid_s2, ready_s1, ready_s2;
	tpc_pkg::tri_t tri_s1, tri_s2;
	logic signed [63:0] prod_s1 [3][4];
	logic signed [DW-1:0] ps_s2 [3][2];

	assign ready_s2     = !valid_s2 || push_ready;
	assign ready_s1     = !valid_s1 || ready_s2;
	assign tri_in.ready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= tri_in.valid;
			if (ready_s2) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && tri_in.valid) begin
			tri_s1 <= vin;
			for (int i = 0; i < 3; i++)
				for (int c = 0; c < 4; c++)
					prod_s1[i][c] <= $signed(vin[i][c]) * plane_q[c];
		end
	end

	logic signed [63:0] sh [3][4];
	always_comb begin
		for (int i = 0; i < 3; i++)
			for (int c = 0; c < 4; c++)
				sh[i][c] = prod_s1[i][c] >>> FRAC_BITS;
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			tri_s2 <= tri_s1;
			for (int i = 0; i < 3; i++) begin
				ps_s2[i][0] <= sh[i][0][DW-1:0] + sh[i][1][DW-1:0];
				ps_s2[i][1] <= sh[i][2][DW-1:0] + sh[i][3][DW-1:0];
			end
		end
	end

	assign push_valid = valid_s2;
	assign push_tri   = tri_s2;
	always_comb begin
		for (int i = 0; i < 3; i++)
			push_dist[i] = ps_s2[i][0] + ps_s2[i][1];
	end

endmodule

// ----- rtl/tpc_queue.sv -----
module tpc_queue #(
	parameter int W     = 8,
	parameter int DEPTH = tpc_pkg::QUEUE_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push_valid,
	output logic         push_ready,
	input  logic [W-1:0] push_data,
	output logic         pop_valid,
	input  logic         pop_ready,
	output logic [W-1:0] pop_data
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [CW-1:0] count_q;
	logic          push, pop;

	assign push_ready = count_q != CW'(DEPTH);
	assign pop_valid  = count_q != '0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = mem[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : AW'(wr_q + 1'b1);
			if (pop)  rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : AW'(rd_q + 1'b1);
			if (push && !pop)      count_q <= CW'(count_q + 1'b1);
			else if (pop && !push) count_q <= CW'(count_q - 1'b1);
		end
	end

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH)) else $error("queue count beyond depth");
	a_count_inc: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == CW'($past(count_q) + 1'b1))
		else $error("queue count lost a push");
`endif

endmodule

// ----- rtl/tpc_back.sv -----
module tpc_back #(
	parameter int FRAC_BITS = tpc_pkg::FRAC_BITS_DEF,
	parameter int DW        = tpc_pkg::dist_width(FRAC_BITS)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               pop_valid,
	output logic               pop_ready,
	input  tpc_pkg::tri_t      pop_tri,
	input  logic [2:0][DW-1:0] pop_dist,
	tpc_vtx_if.source          vtx_out
);

	localparam int CW0 = $clog2(FRAC_BITS + 1);
	localparam int CW  = (CW0 > 3) ? CW0 : 3;
	localparam int PW  = 34 + FRAC_BITS;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SETUP = 3'd1;
	localparam logic [2:0] ST_DIV   = 3'd2;
	localparam logic [2:0] ST_MUL   = 3'd3;
	localparam logic [2:0] ST_EMIT  = 3'd4;

	function automatic logic [1:0] add3(input logic [1:0] a, input logic [1:0] b);
		logic [2:0] s;
		s = {1'b0, a} + {1'b0, b};
		return (s >= 3'd3) ? 2'(s - 3'd3) : s[1:0];
	endfunction

	logic [2:0]          state_q;
	tpc_pkg::tri_t       v_q;
	logic [2:0][DW-1:0]  d_q;
	logic [1:0]          base_q;
	logic                one_out_q;
	logic                j_q;
	logic [1:0][3:0][31:0] e_q;
	logic [CW-1:0]       cnt_q;
	logic [DW:0]         r_q;
	logic [DW-1:0]       den_q;
	logic [FRAC_BITS-1:0] t_q;
	logic signed [PW-1:0] prod_q;
	logic [2:0]          step_q;

	logic                out_valid_q;
	tpc_pkg::vtx_t       out_v_q;
	logic                out_eot_q, out_last_q;

	// classify the entry at the queue head
	logic [2:0] mask;
	logic [1:0] n_out, base_in;
	always_comb begin
		for (int i = 0; i < 3; i++) mask[i] = pop_dist[i][DW-1];
		n_out = 2'({1'b0, mask[0]} + {1'b0, mask[1]} + {1'b0, mask[2]});
		if (n_out == 2'd1) base_in = mask[0] ? 2'd0 : (mask[1] ? 2'd1 : 2'd2);
		else               base_in = !mask[0] ? 2'd0 : (!mask[1] ? 2'd1 : 2'd2);
	end

	logic       out_free, emit_done, can_load, pop;
	logic [2:0] step_last;
	assign out_free  = !out_valid_q || vtx_out.ready;
	assign step_last = (state_q == ST_EMIT && one_out_q) ? 3'd5 : 3'd2;
	assign emit_done = (state_q == ST_EMIT) && out_free && (step_q == step_last);
	assign can_load  = (state_q == ST_IDLE) || emit_done;
	assign pop       = can_load && pop_valid;
	assign pop_ready = can_load;

	// endpoints of the current crossing edge: p inside, q outside
	logic [1:0] pi, qi, off;
	always_comb begin
		off = j_q ? 2'd2 : 2'd1;
		if (one_out_q) begin
			pi = add3(base_q, off);
			qi = base_q;
		end else begin
			pi = base_q;
			qi = add3(base_q, off);
		end
	end

	// restoring divide step
	logic [DW+1:0] r2;
	logic          ge;
	always_comb begin
		r2 = {r_q, 1'b0};
		ge = r2 >= {2'b00, den_q};
	end

	// coordinate interpolation
	logic [1:0]          cc, cp;
	logic signed [32:0]  diff;
	logic signed [PW-1:0] psh;
	always_comb begin
		cc   = cnt_q[1:0];
		cp   = 2'(cnt_q - 1'b1);
		diff = $signed({v_q[qi][cc][31], v_q[qi][cc]})
		     - $signed({v_q[pi][cc][31], v_q[pi][cc]});
		psh  = prod_q >>> FRAC_BITS;
	end

	// emission select
	tpc_pkg::vtx_t sel_v;
	always_comb begin
		sel_v = v_q[0];
		if (!one_out_q && base_q == 2'd0 && d_q[0][DW-1] == 1'b0 &&
			d_q[1][DW-1] == 1'b0 && d_q[2][DW-1] == 1'b0) begin
			sel_v = v_q[step_q[1:0]];
		end else if (one_out_q) begin
			case (step_q)
				3'd0, 3'd3: sel_v = e_q[0];
				3'd1:       sel_v = v_q[add3(base_q, 2'd1)];
				3'd2, 3'd4: sel_v = v_q[add3(base_q, 2'd2)];
				default:    sel_v = e_q[1];
			endcase
		end else begin
			case (step_q)
				3'd0:    sel_v = v_q[base_q];
				3'd1:    sel_v = e_q[0];
				default: sel_v = e_q[1];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			j_q         <= 1'b0;
			cnt_q       <= '0;
			step_q      <= '0;
		end else begin
			if (state_q == ST_EMIT && out_free) out_valid_q <= 1'b1;
			else if (vtx_out.ready)             out_valid_q <= 1'b0;
			if (can_load) begin
				j_q    <= 1'b0;
				step_q <= '0;
				if (!pop)                state_q <= ST_IDLE;
				else if (n_out == 2'd3)  state_q <= ST_IDLE;
				else if (n_out == 2'd0)  state_q <= ST_EMIT;
				else                     state_q <= ST_SETUP;
			end else begin
				unique case (state_q)
					ST_SETUP: begin
						cnt_q   <= '0;
						state_q <= ST_DIV;
					end
					ST_DIV: begin
						if (cnt_q == CW'(FRAC_BITS - 1)) begin
							cnt_q   <= '0;
							state_q <= ST_MUL;
						end else
							cnt_q <= CW'(cnt_q + 1'b1);
					end
					ST_MUL: begin
						if (cnt_q == CW'(4)) begin
							cnt_q <= '0;
							if (!j_q) begin
								j_q     <= 1'b1;
								state_q <= ST_SETUP;
							end else begin
								step_q  <= '0;
								state_q <= ST_EMIT;
							end
						end else
							cnt_q <= CW'(cnt_q + 1'b1);
					end
					ST_EMIT: begin
						if (out_free) step_q <= 3'(step_q + 1'b1);
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			v_q       <= pop_tri;
			d_q       <= pop_dist;
			base_q    <= (n_out == 2'd0) ? 2'd0 : base_in;
			one_out_q <= n_out == 2'd1;
		end
		if (state_q == ST_SETUP) begin
			r_q   <= {1'b0, d_q[pi]};
			den_q <= d_q[pi] - d_q[qi];
			t_q   <= '0;
		end
		if (state_q == ST_DIV) begin
			r_q <= ge ? (DW+1)'(r2 - {2'b00, den_q}) : r2[DW:0];
			t_q <= {t_q[FRAC_BITS-2:0], ge};
		end
		if (state_q == ST_MUL) begin
			if (cnt_q != CW'(4)) prod_q <= diff * $signed({1'b0, t_q});
			if (cnt_q != '0) e_q[j_q][cp] <= v_q[pi][cp] + psh[31:0];
		end
		if (state_q == ST_EMIT && out_free) begin
			out_v_q    <= sel_v;
			out_eot_q  <= (step_q == 3'd2) || (step_q == 3'd5);
			out_last_q <= step_q == step_last;
		end
	end

	assign vtx_out.valid           = out_valid_q;
	assign vtx_out.out_x           = out_v_q[0];
	assign vtx_out.out_y           = out_v_q[1];
	assign vtx_out.out_z           = out_v_q[2];
	assign vtx_out.out_w           = out_v_q[3];
	assign vtx_out.end_of_triangle = out_eot_q;
	assign vtx_out.last            = out_last_q;

`ifndef NO_ASSERTIONS
	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (r_q < {1'b0, den_q}))
		else $error("divider remainder not below divisor");
	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (cnt_q < CW'(FRAC_BITS)))
		else $error("divider ran past fraction width");
`endif

endmodule

// ----- rtl/triangle_plane_clipper.sv -----
// triangle plane clipper
// tri_in carries one triangle (three x, y, z, w vertices, signed fixed point)
// per transfer; vtx_out carries clipped vertices, three per emitted triangle,
// with end_of_triangle on each third vertex and last on the final vertex of
// an input triangle. a fully clipped triangle produces no transfer at all.
// the plane lives in four registers written through cfg_we / cfg_index /
// cfg_data; write them only while no triangle is in flight.
// front: two stage distance pipe (12 products, then sums), one triangle per
// cycle while not stalled, feeding a two entry queue. back: sequencer that
// emits one vertex per cycle while vtx_out is ready, via an output register.
// an unclipped triangle goes straight to emitting its three vertices. a
// clipped triangle first runs, for each of its two crossing edges, a setup,
// a restoring divide and a coordinate interpolation, then emits 3 or 6 vertices.
// each triangle passes both pipe stages and the queue before the back part.
// reset clears the plane to z - w and empties pipe, queue and output.
// when vtx_out stalls the output register holds, the back part waits and
// the queue then the front pipe fill before tri_in.ready drops.
module triangle_plane_clipper #(
	parameter int FRAC_BITS = tpc_pkg::FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	tpc_tri_if.sink     tri_in,
	tpc_vtx_if.source   vtx_out,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int DW = tpc_pkg::dist_width(FRAC_BITS);
	// queue entry: distances above the triangle
	localparam int QW = 3 * DW + $bits(tpc_pkg::tri_t);

	logic               push_valid, push_ready, pop_valid, pop_ready;
	tpc_pkg::tri_t      push_tri, pop_tri;
	logic [2:0][DW-1:0] push_dist, pop_dist;
	logic [QW-1:0]      pop_data;

	tpc_front #(.FRAC_BITS(FRAC_BITS), .DW(DW)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.tri_in     (tri_in),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_tri   (push_tri),
		.push_dist  (push_dist)
	);

	tpc_queue #(.W(QW), .DEPTH(tpc_pkg::QUEUE_DEPTH)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  ({push_dist, push_tri}),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	// split the queue head back into distances and triangle
	assign pop_tri  = pop_data[$bits(tpc_pkg::tri_t)-1:0];
	assign pop_dist = pop_data[QW-1:$bits(tpc_pkg::tri_t)];

	tpc_back #(.FRAC_BITS(FRAC_BITS), .DW(DW)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_tri   (pop_tri),
		.pop_dist  (pop_dist),
		.vtx_out   (vtx_out)
	);

endmodule
